// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the trajectory steering controller.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned PosW  = 24;
  localparam int unsigned DiffW = 25;
  localparam int unsigned AngW  = 16;
  localparam int unsigned HerrW = 17;
  localparam int unsigned CmdW  = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned MaxW  = 15;
  localparam int unsigned TrigW = 18;
  localparam int unsigned CordW = 34;

  localparam logic signed [AngW-1:0]  HalfPiQ13 = 16'sd12868;
  localparam logic signed [AngW-1:0]  PiQ13     = 16'sd25736;
  localparam logic signed [HerrW-1:0] PiQ13W    = 17'sd25736;
  localparam logic signed [HerrW-1:0] TwoPiQ13  = 17'sd51472;
  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegTripGain    = 3'd0;
  localparam logic [2:0] RegHeadingGain = 3'd1;
  localparam logic [2:0] RegLateralGain = 3'd2;
  localparam logic [2:0] RegMaxTurn     = 3'd3;
  localparam logic [2:0] RegDriveMode   = 3'd4;

  localparam logic [1:0] ModeSpeed   = 2'd0;
  localparam logic [1:0] ModeTurn    = 2'd1;
  localparam logic [1:0] ModeReverse = 2'd2;
  localparam logic [1:0] ModeZero    = 2'd3;

  // Per-item values that travel alongside the CORDIC.
  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [HerrW-1:0] herr;
    logic signed [CmdW-1:0]  des_v;
    logic signed [CmdW-1:0]  des_w;
  } side_t;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CordW-1:0] r;
    case (idx)
      5'd0:  r = 34'sh03243F6A9;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/tsc_cordic.sv
// ----------------------------------------------------------------------------
// tsc_cordic
// Unrolled rotation-mode CORDIC giving cosine and sine of a heading in Q16,
// one register per iteration, with a side vector carried alongside.
// ----------------------------------------------------------------------------
module tsc_cordic #(
  parameter int unsigned Stages = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [tsc_pkg::AngW-1:0]   ang_i,
  input  tsc_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [tsc_pkg::TrigW-1:0]  cos_o,
  output logic signed [tsc_pkg::TrigW-1:0]  sin_o,
  output tsc_pkg::side_t                    side_o
);

  localparam int unsigned W = tsc_pkg::CordW;

  logic signed [W-1:0] x_q [Stages+1];
  logic signed [W-1:0] y_q [Stages+1];
  logic signed [W-1:0] z_q [Stages+1];
  logic                neg_q [Stages+1];
  logic                vld_q [Stages+1];
  tsc_pkg::side_t      side_q [Stages+1];

  logic signed [tsc_pkg::AngW-1:0] fold_d;
  logic                            neg_d;

  // Fold the heading into [-pi/2, pi/2]; the result is negated at the end.
  always_comb begin
    fold_d = ang_i;
    neg_d  = 1'b0;
    if (ang_i > tsc_pkg::HalfPiQ13) begin
      fold_d = ang_i - tsc_pkg::PiQ13;
      neg_d  = 1'b1;
    end else if (ang_i < -tsc_pkg::HalfPiQ13) begin
      fold_d = ang_i + tsc_pkg::PiQ13;
      neg_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= tsc_pkg::GainQ30;
    y_q[0]    <= '0;
    z_q[0]    <= W'(fold_d) <<< 17;
    neg_q[0]  <= neg_d;
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [W-1:0] xs, ys, at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = tsc_pkg::atan_q30(5'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (z_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - at;
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + at;
      end
      neg_q[i+1]  <= neg_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  logic signed [W-1:0]                 xr, yr;
  logic signed [tsc_pkg::TrigW-1:0]    cr, sr;
  logic signed [tsc_pkg::TrigW-1:0]    cos_q, sin_q;
  logic                                vout_q;
  tsc_pkg::side_t                      sout_q;

  assign xr = (x_q[Stages] + W'(8192)) >>> 14;
  assign yr = (y_q[Stages] + W'(8192)) >>> 14;
  assign cr = xr[tsc_pkg::TrigW-1:0];
  assign sr = yr[tsc_pkg::TrigW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= vld_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= neg_q[Stages] ? -cr : cr;
    sin_q  <= neg_q[Stages] ? -sr : sr;
    sout_q <= side_q[Stages];
  end

  assign valid_o = vout_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;
  assign side_o  = sout_q;

endmodule

// File: rtl/tsc_law.sv
// ----------------------------------------------------------------------------
// tsc_law
// Control law: projections, gain products, command sums, rounding,
// turn clamp and drive mode selection over five register stages.
// ----------------------------------------------------------------------------
module tsc_law (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [tsc_pkg::TrigW-1:0]  cos_i,
  input  logic signed [tsc_pkg::TrigW-1:0]  sin_i,
  input  tsc_pkg::side_t                    side_i,
  input  logic [tsc_pkg::GainW-1:0]         trip_gain_i,
  input  logic [tsc_pkg::GainW-1:0]         heading_gain_i,
  input  logic [tsc_pkg::GainW-1:0]         lateral_gain_i,
  input  logic [tsc_pkg::MaxW-1:0]          max_turn_i,
  input  logic [1:0]                        mode_i,
  output logic                              valid_o,
  output logic signed [tsc_pkg::CmdW-1:0]   speed_o,
  output logic signed [tsc_pkg::CmdW-1:0]   turn_o,
  output logic                              clamped_o
);

  localparam int unsigned CmdW = tsc_pkg::CmdW;

  // Stage 1: four projection products.
  logic              v1_q;
  logic signed [42:0] dxc_q, dys_q, dyc_q, dxs_q;
  tsc_pkg::side_t    s1_q;

  always_ff @(posedge clk_i) begin
    dxc_q <= 43'(side_i.dx * cos_i);
    dys_q <= 43'(side_i.dy * sin_i);
    dyc_q <= 43'(side_i.dy * cos_i);
    dxs_q <= 43'(side_i.dx * sin_i);
    s1_q  <= side_i;
  end

  // Stage 2: trip and lateral errors, heading gain product.
  logic               v2_q;
  logic signed [43:0] trip_q, lat_q;
  logic signed [33:0] hprod_q;
  logic signed [CmdW-1:0] dv2_q, dw2_q;

  always_ff @(posedge clk_i) begin
    trip_q  <= 44'(dxc_q) + 44'(dys_q);
    lat_q   <= 44'(dyc_q) - 44'(dxs_q);
    hprod_q <= 34'($signed({1'b0, heading_gain_i}) * s1_q.herr);
    dv2_q   <= s1_q.des_v;
    dw2_q   <= s1_q.des_w;
  end

  // Stage 3: gain products split into low and high halves of the error.
  logic               v3_q;
  logic signed [39:0] tlo_q, llo_q;
  logic signed [38:0] thi_q, lhi_q;
  logic signed [33:0] hprod3_q;
  logic signed [CmdW-1:0] dv3_q, dw3_q;
  logic signed [16:0] tg, lg;

  assign tg = $signed({1'b0, trip_gain_i});
  assign lg = $signed({1'b0, lateral_gain_i});

  always_ff @(posedge clk_i) begin
    tlo_q    <= 40'(tg * $signed({1'b0, trip_q[21:0]}));
    thi_q    <= 39'(tg * $signed(trip_q[43:22]));
    llo_q    <= 40'(lg * $signed({1'b0, lat_q[21:0]}));
    lhi_q    <= 39'(lg * $signed(lat_q[43:22]));
    hprod3_q <= hprod_q;
    dv3_q    <= dv2_q;
    dw3_q    <= dw2_q;
  end

  // Stage 4: exact Q36 command sums.
  logic               v4_q;
  logic signed [63:0] accs_q, acct_q;
  logic signed [CmdW-1:0] dv4_q, dw4_q;

  always_ff @(posedge clk_i) begin
    accs_q <= (64'(dv3_q) <<< 24) + (64'(thi_q) <<< 22) + 64'(tlo_q);
    acct_q <= (64'(dw3_q) <<< 24) + (64'(hprod3_q) <<< 15)
              + (64'(lhi_q) <<< 22) + 64'(llo_q);
    dv4_q  <= dv3_q;
    dw4_q  <= dw3_q;
  end

  // Stage 5: rounding, saturation, clamp and mode.
  logic signed [63:0] rs, rt;
  logic signed [39:0] sp40, tu40, m40;
  logic signed [CmdW-1:0] sp_sat, tu_clp, rev;
  logic               clp;
  logic signed [CmdW:0] negv;
  logic signed [CmdW-1:0] spd_d, trn_d;
  logic               clp_d;

  always_comb begin
    rs   = (accs_q + 64'sd8388608) >>> 24;
    rt   = (acct_q + 64'sd8388608) >>> 24;
    sp40 = rs[39:0];
    tu40 = rt[39:0];
    m40  = $signed({25'd0, max_turn_i});
    if (sp40 > 40'sd32767) begin
      sp_sat = 16'sh7FFF;
    end else if (sp40 < -40'sd32768) begin
      sp_sat = 16'sh8000;
    end else begin
      sp_sat = sp40[CmdW-1:0];
    end
    clp = 1'b0;
    if (tu40 > m40) begin
      tu_clp = m40[CmdW-1:0];
      clp    = 1'b1;
    end else if (tu40 < -m40) begin
      tu_clp = CmdW'(-m40);
      clp    = 1'b1;
    end else begin
      tu_clp = tu40[CmdW-1:0];
    end
    negv = -(17'(dv4_q));
    rev  = (negv > 17'sd32767) ? 16'sh7FFF : negv[CmdW-1:0];
    spd_d = '0;
    trn_d = '0;
    clp_d = 1'b0;
    unique case (mode_i)
      tsc_pkg::ModeSpeed: begin
        spd_d = sp_sat;
      end
      tsc_pkg::ModeTurn: begin
        trn_d = tu_clp;
        clp_d = clp;
      end
      tsc_pkg::ModeReverse: begin
        spd_d = rev;
        trn_d = dw4_q;
      end
      default: begin
      end
    endcase
  end

  logic               v5_q;
  logic signed [CmdW-1:0] spd_q, trn_q;
  logic               clp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      spd_q <= '0;
      trn_q <= '0;
      clp_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      if (v4_q) begin
        spd_q <= spd_d;
        trn_q <= trn_d;
        clp_q <= clp_d;
      end
    end
  end

  assign valid_o   = v5_q;
  assign speed_o   = spd_q;
  assign turn_o    = trn_q;
  assign clamped_o = clp_q;

endmodule

// File: rtl/trajectory_steering_controller.sv
// ----------------------------------------------------------------------------
// trajectory_steering_controller
// Pose tracking controller giving speed and turn-rate commands per tick.
// ----------------------------------------------------------------------------
// Usage: raise start with a pose item on the input ports; it is taken at any
// rising edge with start high, since busy is always low. One item may be
// given in every cycle.
// Each item gives one result, shown on speed_cmd_o, turn_cmd_o and
// turn_clamped_o for a single cycle while done_o is high. Each item passes
// through one input stage, the fold, one stage per CORDIC iteration, one
// rounding stage and five control-law stages. Throughput is one item per
// cycle, set by the fully unrolled CORDIC and multiplier chain.
// The receiver cannot stall; results are simply presented and dropped.
// The user writes gains, turn limit and drive mode over the APB port only
// while no item is in flight; the block does not enforce this. Reset clears
// pipeline valid bits; defaults: gains 0, turn limit 0.5 rad/s, mode zero.
// ----------------------------------------------------------------------------
module trajectory_steering_controller #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tsc_pkg::PosW-1:0]   des_x_i,
  input  logic signed [tsc_pkg::PosW-1:0]   des_y_i,
  input  logic signed [tsc_pkg::AngW-1:0]   des_heading_i,
  input  logic signed [tsc_pkg::CmdW-1:0]   des_speed_i,
  input  logic signed [tsc_pkg::CmdW-1:0]   des_turn_rate_i,
  input  logic signed [tsc_pkg::PosW-1:0]   cur_x_i,
  input  logic signed [tsc_pkg::PosW-1:0]   cur_y_i,
  input  logic signed [tsc_pkg::AngW-1:0]   cur_heading_i,
  output logic                              done_o,
  output logic signed [tsc_pkg::CmdW-1:0]   speed_cmd_o,
  output logic signed [tsc_pkg::CmdW-1:0]   turn_cmd_o,
  output logic                              turn_clamped_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned Latency = CORDIC_STAGES + 8;

  // Configuration registers.
  logic [tsc_pkg::GainW-1:0] trip_gain_q, heading_gain_q, lateral_gain_q;
  logic [tsc_pkg::MaxW-1:0]  max_turn_q;
  logic [1:0]                mode_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_gain_q    <= '0;
      heading_gain_q <= '0;
      lateral_gain_q <= '0;
      max_turn_q     <= 15'd2048;
      mode_q         <= tsc_pkg::ModeZero;
    end else if (wr_en) begin
      case (paddr[4:2])
        tsc_pkg::RegTripGain:    trip_gain_q    <= pwdata[15:0];
        tsc_pkg::RegHeadingGain: heading_gain_q <= pwdata[15:0];
        tsc_pkg::RegLateralGain: lateral_gain_q <= pwdata[15:0];
        tsc_pkg::RegMaxTurn:     max_turn_q     <= pwdata[14:0];
        tsc_pkg::RegDriveMode:   mode_q         <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tsc_pkg::RegTripGain:    prdata = {16'd0, trip_gain_q};
      tsc_pkg::RegHeadingGain: prdata = {16'd0, heading_gain_q};
      tsc_pkg::RegLateralGain: prdata = {16'd0, lateral_gain_q};
      tsc_pkg::RegMaxTurn:     prdata = {17'd0, max_turn_q};
      tsc_pkg::RegDriveMode:   prdata = {30'd0, mode_q};
      default:                 prdata = '0;
    endcase
  end

  // Input stage: position differences and the wrapped heading error.
  logic                                  in_vld_q;
  logic signed [tsc_pkg::AngW-1:0]       ang_q;
  tsc_pkg::side_t                        side_q;
  logic signed [tsc_pkg::HerrW-1:0]      hd, hw;

  always_comb begin
    hd = tsc_pkg::HerrW'(des_heading_i) - tsc_pkg::HerrW'(cur_heading_i);
    if (hd > tsc_pkg::PiQ13W) begin
      hw = hd - tsc_pkg::TwoPiQ13;
    end else if (hd < -tsc_pkg::PiQ13W) begin
      hw = hd + tsc_pkg::TwoPiQ13;
    end else begin
      hw = hd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q        <= des_heading_i;
    side_q.dx    <= tsc_pkg::DiffW'(des_x_i) - tsc_pkg::DiffW'(cur_x_i);
    side_q.dy    <= tsc_pkg::DiffW'(des_y_i) - tsc_pkg::DiffW'(cur_y_i);
    side_q.herr  <= hw;
    side_q.des_v <= des_speed_i;
    side_q.des_w <= des_turn_rate_i;
  end

  logic                             cv;
  logic signed [tsc_pkg::TrigW-1:0] cs, sn;
  tsc_pkg::side_t                   cside;

  tsc_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .ang_i   (ang_q),
    .side_i  (side_q),
    .valid_o (cv),
    .cos_o   (cs),
    .sin_o   (sn),
    .side_o  (cside)
  );

  tsc_law u_law (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (cv),
    .cos_i          (cs),
    .sin_i          (sn),
    .side_i         (cside),
    .trip_gain_i    (trip_gain_q),
    .heading_gain_i (heading_gain_q),
    .lateral_gain_i (lateral_gain_q),
    .max_turn_i     (max_turn_q),
    .mode_i         (mode_q),
    .valid_o        (done_o),
    .speed_o        (speed_cmd_o),
    .turn_o         (turn_cmd_o),
    .clamped_o      (turn_clamped_o)
  );

  // Every accepted item leaves the pipeline with a done_o strobe.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("result strobe missing after pipeline latency");

  // A clamp flag can only come out in turn-only mode.
  a_clamp_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && turn_clamped_o) |-> (mode_q == tsc_pkg::ModeTurn))
    else $error("clamp flag outside turn-only mode");

  // Zero mode gives zero commands.
  a_zero_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && mode_q == tsc_pkg::ModeZero) |->
      (speed_cmd_o == '0 && turn_cmd_o == '0 && !turn_clamped_o))
    else $error("nonzero command in zero mode");

endmodule

// File: sim/trajectory_steering_controller_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_steering_controller_chk
// Watches the pose channel, the command channel and register writes. Each
// accepted pose item is turned into the expected speed and turn command,
// which is then compared field by field with the next result that appears.
// ----------------------------------------------------------------------------
module trajectory_steering_controller_chk #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [tsc_pkg::PosW-1:0] des_x_i,
  input  logic signed [tsc_pkg::PosW-1:0] des_y_i,
  input  logic signed [tsc_pkg::AngW-1:0] des_heading_i,
  input  logic signed [tsc_pkg::CmdW-1:0] des_speed_i,
  input  logic signed [tsc_pkg::CmdW-1:0] des_turn_rate_i,
  input  logic signed [tsc_pkg::PosW-1:0] cur_x_i,
  input  logic signed [tsc_pkg::PosW-1:0] cur_y_i,
  input  logic signed [tsc_pkg::AngW-1:0] cur_heading_i,
  input  logic                            done_o,
  input  logic signed [tsc_pkg::CmdW-1:0] speed_cmd_o,
  input  logic signed [tsc_pkg::CmdW-1:0] turn_cmd_o,
  input  logic                            turn_clamped_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [4:0]                      paddr,
  input  logic [31:0]                     pwdata,
  input  logic                            pready,
  output int                              errors_o,
  output int                              pending_o
);

  typedef struct packed {
    logic signed [tsc_pkg::CmdW-1:0] speed;
    logic signed [tsc_pkg::CmdW-1:0] turn;
    logic                            clamped;
  } command_t;

  localparam longint ArcTanQ30 [24] = '{
    64'h3243F6A9, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  logic [tsc_pkg::GainW-1:0] trip_gain_q, heading_gain_q, lateral_gain_q;
  logic [tsc_pkg::MaxW-1:0]  max_turn_q;
  logic [1:0]                mode_q;
  command_t                  cmd_due_q [$];
  int                        errors = 0;

  assign errors_o  = errors;
  assign pending_o = cmd_due_q.size();

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic command_t steer_command();
    longint h, x, y, z, t, c, s, dx, dy, trip, lat, herr, acc, speed, turn, lim;
    logic   neg;
    command_t r;
    neg = 1'b0;
    h = des_heading_i;
    // Headings beyond a quarter turn are folded by half a turn first.
    if (h > 12868) begin
      h -= 25736;
      neg = 1'b1;
    end else if (h < -12868) begin
      h += 25736;
      neg = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = h * 131072;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ArcTanQ30[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ArcTanQ30[i];
      end
      x = t;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (neg) begin
      c = -c;
      s = -s;
    end
    dx = longint'(des_x_i) - longint'(cur_x_i);
    dy = longint'(des_y_i) - longint'(cur_y_i);
    trip = dx * c + dy * s;
    lat = dy * c - dx * s;
    herr = longint'(des_heading_i) - longint'(cur_heading_i);
    while (herr > 25736) herr -= 51472;
    while (herr < -25736) herr += 51472;
    acc = longint'(des_speed_i) * 16777216 + longint'(trip_gain_q) * trip;
    speed = clip16((acc + 8388608) >>> 24);
    acc = longint'(des_turn_rate_i) * 16777216 + longint'(heading_gain_q) * herr * 32768
          + longint'(lateral_gain_q) * lat;
    turn = (acc + 8388608) >>> 24;
    lim = longint'(max_turn_q);
    r = '0;
    case (mode_q)
      tsc_pkg::ModeSpeed: r.speed = speed[tsc_pkg::CmdW-1:0];
      tsc_pkg::ModeTurn: begin
        if (turn > lim) begin
          turn = lim;
          r.clamped = 1'b1;
        end else if (turn < -lim) begin
          turn = -lim;
          r.clamped = 1'b1;
        end
        r.turn = turn[tsc_pkg::CmdW-1:0];
      end
      tsc_pkg::ModeReverse: begin
        speed = clip16(-longint'(des_speed_i));
        r.speed = speed[tsc_pkg::CmdW-1:0];
        r.turn = des_turn_rate_i;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    command_t due;
    if (!rst_ni) begin
      trip_gain_q    <= '0;
      heading_gain_q <= '0;
      lateral_gain_q <= '0;
      max_turn_q     <= 15'd2048;
      mode_q         <= tsc_pkg::ModeZero;
    end else begin
      if (done_o) begin
        if (cmd_due_q.size() == 0) begin
          report_mismatch("command with no pose item waiting");
        end else begin
          due = cmd_due_q.pop_front();
          if (speed_cmd_o !== due.speed)
            report_mismatch($sformatf("speed_cmd %0d, expected %0d", speed_cmd_o, due.speed));
          if (turn_cmd_o !== due.turn)
            report_mismatch($sformatf("turn_cmd %0d, expected %0d", turn_cmd_o, due.turn));
          if (turn_clamped_o !== due.clamped)
            report_mismatch($sformatf("turn_clamped %0b, expected %0b", turn_clamped_o,
                                      due.clamped));
        end
      end
      if (start && !busy) cmd_due_q = {cmd_due_q, steer_command()};
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[4:2])
          tsc_pkg::RegTripGain:    trip_gain_q    <= pwdata[tsc_pkg::GainW-1:0];
          tsc_pkg::RegHeadingGain: heading_gain_q <= pwdata[tsc_pkg::GainW-1:0];
          tsc_pkg::RegLateralGain: lateral_gain_q <= pwdata[tsc_pkg::GainW-1:0];
          tsc_pkg::RegMaxTurn:     max_turn_q     <= pwdata[tsc_pkg::MaxW-1:0];
          tsc_pkg::RegDriveMode:   mode_q         <= pwdata[1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sim/trajectory_steering_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_steering_controller_tb
// Drives pose items in bursts through several gain, limit and mode settings,
// written over the register port while the pipeline is empty. The checker
// predicts each command and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module trajectory_steering_controller_tb;

  localparam int unsigned Stages  = 16;
  localparam int          Latency = Stages + 8;
  localparam int          IdleMax = 4000;

  logic clk_i, rst_ni, start, busy, done_o, turn_clamped_o;
  logic signed [tsc_pkg::PosW-1:0] des_x_i, des_y_i, cur_x_i, cur_y_i;
  logic signed [tsc_pkg::AngW-1:0] des_heading_i, cur_heading_i;
  logic signed [tsc_pkg::CmdW-1:0] des_speed_i, des_turn_rate_i, speed_cmd_o, turn_cmd_o;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending, burst_left;
  int          idle_cycles = 0;

  trajectory_steering_controller #(.CORDIC_STAGES(Stages)) u_top (.*);
  trajectory_steering_controller_chk #(.CORDIC_STAGES(Stages)) u_chk (
    .*, .errors_o(errors), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleMax) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the sender back until every command is out and the pipe is empty.
  task automatic drain();
    if (start) start <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic send_pose(logic signed [tsc_pkg::PosW-1:0] dxp, dyp, cxp, cyp,
                           logic signed [tsc_pkg::AngW-1:0] dh, ch,
                           logic signed [tsc_pkg::CmdW-1:0] dv, dw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap != 0) begin
        if (start) start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    start <= 1'b1;
    des_x_i <= dxp; des_y_i <= dyp; cur_x_i <= cxp; cur_y_i <= cyp;
    des_heading_i <= dh; cur_heading_i <= ch;
    des_speed_i <= dv; des_turn_rate_i <= dw;
    do @(posedge clk_i); while (busy);
    burst_left--;
  endtask

  task automatic random_pose();
    logic [31:0] r [8];
    logic signed [tsc_pkg::PosW-1:0] dx, dy;
    logic signed [tsc_pkg::AngW-1:0] dh, ch;
    foreach (r[k]) r[k] = $urandom();
    dh = ($urandom_range(0, 9) == 0) ? r[2][15:0] : 16'($urandom_range(0, 51472) - 25736);
    ch = ($urandom_range(0, 9) == 0) ? r[7][15:0] : 16'($urandom_range(0, 51472) - 25736);
    // Mostly nearby poses, so the error terms stay in a useful range.
    if ($urandom_range(0, 3) != 0) begin
      dx = r[0][23:0];
      dy = r[1][23:0];
      send_pose(dx, dy, dx + $signed(r[5][12:0]), dy + $signed(r[6][12:0]), dh, ch,
                r[3][15:0], r[4][15:0]);
    end else begin
      send_pose(r[0][23:0], r[1][23:0], r[5][23:0], r[6][23:0], dh, ch,
                r[3][15:0], r[4][15:0]);
    end
  endtask

  initial begin
    logic signed [tsc_pkg::AngW-1:0] heads [10];
    heads = '{16'sd0, 16'sd12868, 16'sd12869, -16'sd12868, -16'sd12869, 16'sd25736,
              -16'sd25736, 16'sd32767, -16'sd32768, 16'sd4000};
    rst_ni = 1'b0; start = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; burst_left = 0;
    des_x_i = '0; des_y_i = '0; cur_x_i = '0; cur_y_i = '0;
    des_heading_i = '0; cur_heading_i = '0; des_speed_i = '0; des_turn_rate_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings first: the zero mode.
    send_pose(24'sd4096, -24'sd4096, '0, '0, 16'sd1000, '0, 16'sd4096, -16'sd4096);
    drain();

    write_reg(tsc_pkg::RegTripGain, 32'h0000_0180);
    write_reg(tsc_pkg::RegHeadingGain, 32'h0000_0200);
    write_reg(tsc_pkg::RegLateralGain, 32'h0000_0080);
    write_reg(tsc_pkg::RegMaxTurn, 32'h0000_0800);
    for (int m = 0; m < 3; m++) begin
      write_reg(tsc_pkg::RegDriveMode, m);
      foreach (heads[k])
        send_pose(k[0] ? 24'sh7FFFFF : 24'sh000800, k[0] ? 24'sh800000 : -24'sh000400,
                  k[0] ? 24'sh800000 : '0, k[0] ? 24'sh7FFFFF : '0, heads[k],
                  heads[9 - k], k[1] ? 16'sh8000 : 16'sh7FFF, k[2] ? 16'sh8000 : 16'sh7FFF);
      drain();
    end

    for (int phase = 0; phase < 10; phase++) begin
      write_reg(tsc_pkg::RegTripGain, phase == 1 ? 32'hFFFF : (phase == 2 ? 0 : $urandom()));
      write_reg(tsc_pkg::RegHeadingGain, phase == 1 ? 32'hFFFF : $urandom_range(0, 2048));
      write_reg(tsc_pkg::RegLateralGain, phase == 3 ? 32'hFFFF : $urandom_range(0, 1024));
      write_reg(tsc_pkg::RegMaxTurn, phase == 4 ? 1 : (phase == 5 ? 32'h7FFF :
                            (phase == 6 ? 0 : $urandom_range(1, 32767))));
      write_reg(tsc_pkg::RegDriveMode,
                32'(phase % 4 == 3 ? tsc_pkg::ModeZero : (phase % 2 ? tsc_pkg::ModeTurn :
                    (phase % 4 == 0 ? tsc_pkg::ModeSpeed : tsc_pkg::ModeReverse))));
      repeat (40) random_pose();
      drain();
    end

    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tsc_pkg.sv
rtl/tsc_cordic.sv
rtl/tsc_law.sv
rtl/trajectory_steering_controller.sv
sim/trajectory_steering_controller_chk.sv
sim/trajectory_steering_controller_tb.sv
